@@ rtl/core/swqt_pkg.sv @@
package swqt_pkg;

	localparam int unsigned NPROC = 16;
	localparam int unsigned PID_W = 4;
	localparam int unsigned KEY_W = 32;

	typedef enum logic [1:0] {
		REQ_BLOCK   = 2'd0,
		REQ_UNBLOCK = 2'd1,
		REQ_REMOVE  = 2'd2,
		REQ_PEEK    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOFREE     = 3'd1,
		ST_NOKEY      = 3'd2,
		ST_NOTBLOCKED = 3'd3,
		ST_ALREADY    = 3'd4
	} status_t;

	typedef struct packed {
		req_t              req;
		logic [KEY_W-1:0]  key;
		logic [PID_W-1:0]  pid;
	} item_t;

endpackage

@@ rtl/core/swqt_front.sv @@
module swqt_front #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  swqt_pkg::item_t in_item,
	output logic          q_valid,
	input  logic          q_ready,
	output swqt_pkg::item_t q_item
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	swqt_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

@@ rtl/core/swqt_back.sv @@
module swqt_back #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  swqt_pkg::item_t q_item,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    out_status,
	output logic [3:0]    out_pid
);
	localparam int unsigned DW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int unsigned NP = swqt_pkg::NPROC;

	logic [31:0] key_q [MAX_PROCS];
	logic [MAX_PROCS-1:0] act_q;
	logic [3:0] first_q [MAX_PROCS];
	logic [3:0] last_q [MAX_PROCS];
	logic [3:0] next_q [NP];
	logic [3:0] prev_q [NP];
	logic [NP-1:0] wait_q;
	logic [DW-1:0] pdesc_q [NP];

	logic [MAX_PROCS-1:0] hit;
	logic hit_any, free_any;
	logic [DW-1:0] hit_d, free_d, dsel, ud;
	logic [3:0] p, up, head;
	logic go;
	logic do_new, do_app, do_unl;
	logic [2:0] st;
	logic [3:0] pout;
	logic u_first, u_last;

	assign q_ready = !out_valid || out_ready;
	assign go = q_valid && q_ready;
	assign p = q_item.pid;

	always_comb begin
		hit_any = 1'b0;
		hit_d = '0;
		free_any = 1'b0;
		free_d = '0;
		for (int i = MAX_PROCS-1; i >= 0; i--) begin
			hit[i] = act_q[i] && (key_q[i] == q_item.key);
			if (hit[i]) begin
				hit_any = 1'b1;
				hit_d = DW'(i);
			end
			if (!act_q[i]) begin
				free_any = 1'b1;
				free_d = DW'(i);
			end
		end
	end

	always_comb begin
		st = swqt_pkg::ST_OK;
		pout = '0;
		do_new = 1'b0;
		do_app = 1'b0;
		do_unl = 1'b0;
		dsel = hit_d;
		head = first_q[hit_d];
		up = p;
		case (q_item.req)
			swqt_pkg::REQ_BLOCK: begin
				if (wait_q[p]) begin
					st = swqt_pkg::ST_ALREADY;
				end else if (hit_any) begin
					do_app = 1'b1;
					pout = p;
				end else if (free_any) begin
					do_new = 1'b1;
					dsel = free_d;
					pout = p;
				end else begin
					st = swqt_pkg::ST_NOFREE;
				end
			end
			swqt_pkg::REQ_REMOVE: begin
				if (!wait_q[p]) begin
					st = swqt_pkg::ST_NOTBLOCKED;
				end else begin
					do_unl = 1'b1;
					pout = p;
				end
			end
			default: begin
				if (!hit_any) begin
					st = swqt_pkg::ST_NOKEY;
				end else begin
					pout = head;
					up = head;
					do_unl = (q_item.req == swqt_pkg::REQ_UNBLOCK);
				end
			end
		endcase
		ud = pdesc_q[up];
		u_first = (first_q[ud] == up);
		u_last = (last_q[ud] == up);
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (do_new) begin
				key_q[dsel] <= q_item.key;
				first_q[dsel] <= p;
				last_q[dsel] <= p;
				pdesc_q[p] <= dsel;
			end
			if (do_app) begin
				next_q[last_q[dsel]] <= p;
				prev_q[p] <= last_q[dsel];
				last_q[dsel] <= p;
				pdesc_q[p] <= dsel;
			end
			if (do_unl && !(u_first && u_last)) begin
				if (u_first) begin
					first_q[ud] <= next_q[up];
				end else if (u_last) begin
					last_q[ud] <= prev_q[up];
				end else begin
					next_q[prev_q[up]] <= next_q[up];
					prev_q[next_q[up]] <= prev_q[up];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			wait_q <= '0;
			out_valid <= 1'b0;
			out_status <= '0;
			out_pid <= '0;
		end else begin
			if (go) begin
				out_valid <= 1'b1;
				out_status <= st;
				out_pid <= pout;
				if (do_new) begin
					act_q[dsel] <= 1'b1;
				end
				if (do_new || do_app) begin
					wait_q[p] <= 1'b1;
				end
				if (do_unl) begin
					wait_q[up] <= 1'b0;
					if (u_first && u_last) begin
						act_q[ud] <= 1'b0;
					end
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/core/semaphore_wait_queue_table_unit.sv @@
// An accepted request is held in the queue stage, then executed and its result registered.
// One item per cycle while the result output is not stalled; the table is updated as the result is registered.
// A 2-entry queue separates request intake from table execution.
// Reset (arst_n low) empties the queue, frees all descriptors and
// clears all waiting flags; the link and key stores are not cleared.
module semaphore_wait_queue_table_unit #(
	parameter int unsigned MAX_PROCS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // req_type[1:0], sem_key[33:2], proc_id[37:34]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // status[2:0], proc_out[6:3]
);
	swqt_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;
	logic [2:0] st;
	logic [3:0] pid;

	assign in_item.req = swqt_pkg::req_t'(s_axis_tdata[1:0]);
	assign in_item.key = s_axis_tdata[33:2];
	assign in_item.pid = s_axis_tdata[37:34];

	swqt_front #(.DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	swqt_back #(.MAX_PROCS(MAX_PROCS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_status(st), .out_pid(pid)
	);

	assign m_axis_tdata = {1'b0, pid, st};
endmodule

@@ tb/semaphore_wait_queue_table_unit_test.sv @@
module semaphore_wait_queue_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TBL = 16;

	typedef struct {
		swqt_pkg::status_t status;
		logic [3:0]        proc_out;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;

	semaphore_wait_queue_table_unit #(.MAX_PROCS(TBL)) uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// table shadow
	logic [31:0] sh_key[TBL];
	logic        sh_active[TBL];
	logic [3:0]  sh_first[TBL];
	logic [3:0]  sh_last[TBL];
	logic [3:0]  sh_next[16];
	logic [3:0]  sh_prev[16];
	logic        sh_waiting[16];
	logic [3:0]  sh_desc[16];

	answer_t expected_answers[$];
	int  error_count = 0;
	bit  idle_enable = 1'b1;
	bit  sink_hold = 1'b0;
	logic [31:0] key_pool[8];

	function automatic int lookup_key(logic [31:0] k);
		for (int d = 0; d < TBL; d++)
			if (sh_active[d] && sh_key[d] == k)
				return d;
		return -1;
	endfunction

	function automatic void detach_proc(logic [3:0] p);
		int unsigned d;
		bit is_first, is_last;
		d = sh_desc[p];
		is_first = sh_first[d] == p;
		is_last = sh_last[d] == p;
		if (is_first && is_last)
			sh_active[d] = 1'b0;
		else if (is_first)
			sh_first[d] = sh_next[p];
		else if (is_last)
			sh_last[d] = sh_prev[p];
		else begin
			sh_next[sh_prev[p]] = sh_next[p];
			sh_prev[sh_next[p]] = sh_prev[p];
		end
		sh_waiting[p] = 1'b0;
	endfunction

	function automatic answer_t apply_request(swqt_pkg::req_t rq, logic [31:0] k,
		logic [3:0] p);
		answer_t a;
		int d;
		a.status = swqt_pkg::ST_OK;
		a.proc_out = '0;
		case (rq)
			swqt_pkg::REQ_BLOCK: begin
				if (sh_waiting[p])
					a.status = swqt_pkg::ST_ALREADY;
				else begin
					d = lookup_key(k);
					if (d < 0) begin
						for (int i = 0; i < TBL; i++)
							if (!sh_active[i]) begin
								d = i;
								break;
							end
						if (d >= 0) begin
							sh_active[d] = 1'b1;
							sh_key[d] = k;
							sh_first[d] = p;
							sh_last[d] = p;
						end
					end else begin
						sh_next[sh_last[d]] = p;
						sh_prev[p] = sh_last[d];
						sh_last[d] = p;
					end
					if (d < 0)
						a.status = swqt_pkg::ST_NOFREE;
					else begin
						sh_waiting[p] = 1'b1;
						sh_desc[p] = d[3:0];
						a.proc_out = p;
					end
				end
			end
			swqt_pkg::REQ_REMOVE: begin
				if (!sh_waiting[p])
					a.status = swqt_pkg::ST_NOTBLOCKED;
				else begin
					detach_proc(p);
					a.proc_out = p;
				end
			end
			default: begin
				d = lookup_key(k);
				if (d < 0)
					a.status = swqt_pkg::ST_NOKEY;
				else begin
					a.proc_out = sh_first[d];
					if (rq == swqt_pkg::REQ_UNBLOCK)
						detach_proc(a.proc_out);
				end
			end
		endcase
		return a;
	endfunction

	task automatic send_request(swqt_pkg::req_t rq, logic [31:0] k, logic [3:0] p);
		int gap;
		if (idle_enable && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, p, k, rq};
		do @(posedge clk); while (!s_axis_tready);
		expected_answers.push_back(apply_request(rq, k, p));
		@(negedge clk);
	endtask

	// result sink
	always @(negedge clk) begin
		int gap;
		if (sink_hold)
			m_axis_tready <= 1'b0;
		else if (idle_enable && $urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap - 1) @(negedge clk);
		end else
			m_axis_tready <= 1'b1;
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_answers.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				error_count++;
			end else begin
				want = expected_answers.pop_front();
				if (m_axis_tdata[2:0] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
					error_count++;
				end
				if (m_axis_tdata[6:3] !== want.proc_out) begin
					$error("proc_out: expected %0d, got %0d", want.proc_out,
						m_axis_tdata[6:3]);
					error_count++;
				end
				if (m_axis_tdata[7] !== 1'b0) begin
					$error("pad: expected 0, got %b", m_axis_tdata[7]);
					error_count++;
				end
			end
		end
	end

	task automatic test_directed;
		send_request(swqt_pkg::REQ_PEEK, 32'hFFFF_FFFF, 4'd0);
		send_request(swqt_pkg::REQ_UNBLOCK, 32'h0, 4'd0);
		send_request(swqt_pkg::REQ_REMOVE, 32'h0, 4'd15);
		send_request(swqt_pkg::REQ_BLOCK, 32'hFFFF_FFFF, 4'd15);
		send_request(swqt_pkg::REQ_BLOCK, 32'hFFFF_FFFF, 4'd15);
		send_request(swqt_pkg::REQ_BLOCK, 32'hFFFF_FFFF, 4'd0);
		send_request(swqt_pkg::REQ_BLOCK, 32'hFFFF_FFFF, 4'd7);
		send_request(swqt_pkg::REQ_PEEK, 32'hFFFF_FFFF, 4'd3);
		send_request(swqt_pkg::REQ_REMOVE, 32'h0, 4'd0);
		send_request(swqt_pkg::REQ_UNBLOCK, 32'hFFFF_FFFF, 4'd0);
		send_request(swqt_pkg::REQ_UNBLOCK, 32'hFFFF_FFFF, 4'd0);
		send_request(swqt_pkg::REQ_PEEK, 32'hFFFF_FFFF, 4'd0);
		send_request(swqt_pkg::REQ_BLOCK, 32'h0, 4'd2);
		send_request(swqt_pkg::REQ_REMOVE, 32'h0, 4'd2);
	endtask

	// every process on its own key fills the table; a further new key cannot
	// happen since all 16 processes then wait, so the retry by process 4 gets ST_ALREADY
	task automatic test_table_full;
		for (int p = 0; p < 16; p++)
			send_request(swqt_pkg::REQ_BLOCK, 32'hA000_0000 + p, p[3:0]);
		send_request(swqt_pkg::REQ_BLOCK, 32'h5555_5555, 4'd4);
		for (int p = 0; p < 16; p++)
			send_request(swqt_pkg::REQ_UNBLOCK, 32'hA000_0000 + p, 4'd0);
	endtask

	task automatic test_backpressure;
		sink_hold = 1'b1;
		fork
			begin
				repeat (200) @(posedge clk);
				sink_hold = 1'b0;
			end
			for (int i = 0; i < 30; i++)
				send_request(swqt_pkg::req_t'($urandom_range(0, 3)),
					key_pool[$urandom_range(0, 3)], 4'($urandom));
		join
	endtask

	task automatic test_random(int count);
		logic [31:0] k;
		for (int i = 0; i < count; i++) begin
			k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
			send_request(swqt_pkg::req_t'($urandom_range(0, 3)), k, 4'($urandom));
		end
	endtask

	initial begin
		int guard;
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		foreach (sh_active[i])
			sh_active[i] = 1'b0;
		foreach (sh_waiting[i])
			sh_waiting[i] = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_random(1200);
		idle_enable = 1'b0;
		test_random(350);
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (expected_answers.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (error_count == 0 && expected_answers.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
